[rtl/assert_macros.svh]
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[rtl/kmmsa_pkg.sv]
// ----------------------------------------------------------------------------
// kmmsa_pkg
// types and constants shared by the keyed aggregator cells and top level
// ----------------------------------------------------------------------------
package kmmsa_pkg;
    localparam int YEAR_W  = 12;
    localparam int IN_CW   = 16;
    localparam int CNT_W   = 24;
    localparam int PRICE_W = 24;
    localparam int NAME_W  = 16;
    localparam int IN_SW   = 32;
    localparam int SUM_W   = 40;
    localparam int SLOT_W  = 6;
    localparam int S_TDATA_W = 192;
    localparam int M_TDATA_W = 224;

    typedef struct packed {
        logic [SUM_W-1:0]   price_sum;
        logic [NAME_W-1:0]  low_name;
        logic [PRICE_W-1:0] low_price;
        logic [NAME_W-1:0]  top_name;
        logic [PRICE_W-1:0] top_price;
        logic [CNT_W-1:0]   linux_c;
        logic [CNT_W-1:0]   mac_c;
        logic [CNT_W-1:0]   windows_c;
        logic [CNT_W-1:0]   count;
    } entry_t;

    // beat travelling along the cell row
    typedef struct packed {
        logic               vld;
        logic               hit;
        logic [YEAR_W-1:0]  year;
        entry_t             item;
        entry_t             merged;
        logic [9:0]         slot;
    } probe_t;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_OUT} state_t;

    function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    function automatic entry_t merge(input entry_t e, input entry_t it);
        entry_t r;
        r = e;
        r.count     = sat_cnt(e.count, it.count);
        r.windows_c = sat_cnt(e.windows_c, it.windows_c);
        r.mac_c     = sat_cnt(e.mac_c, it.mac_c);
        r.linux_c   = sat_cnt(e.linux_c, it.linux_c);
        r.price_sum = sat_sum(e.price_sum, it.price_sum);
        if (it.top_price > e.top_price) begin
            r.top_price = it.top_price;
            r.top_name  = it.top_name;
        end
        if (it.low_price < e.low_price) begin
            r.low_price = it.low_price;
            r.low_name  = it.low_name;
        end
        return r;
    endfunction
endpackage

[rtl/kmmsa_cell.sv]
// ----------------------------------------------------------------------------
// kmmsa_cell
// one table slot: loads an appended entry, compares the passing probe key, merges on a hit
// ----------------------------------------------------------------------------
module kmmsa_cell #(
    parameter int IDX_W = 6
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [IDX_W-1:0]              idx,
    input  logic                          occupied,
    input  logic                          append,
    input  logic [kmmsa_pkg::YEAR_W-1:0]  app_year,
    input  kmmsa_pkg::entry_t             app_item,
    input  kmmsa_pkg::probe_t             probe_in,
    output kmmsa_pkg::probe_t             probe_out
);
    import kmmsa_pkg::*;

    logic [YEAR_W-1:0] year_reg;
    entry_t            entry_reg;
    probe_t            probe_reg, probe_next;
    logic              match;
    entry_t            merged;

    assign match  = probe_in.vld && occupied && (year_reg == probe_in.year);
    assign merged = merge(entry_reg, probe_in.item);

    always_comb begin
        probe_next = probe_in;
        if (match) begin
            probe_next.hit    = 1'b1;
            probe_next.merged = merged;
            probe_next.slot   = 10'(idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_reg.vld <= 1'b0;
        end else begin
            probe_reg.vld <= probe_next.vld;
        end
        probe_reg.hit    <= probe_next.hit;
        probe_reg.year   <= probe_next.year;
        probe_reg.item   <= probe_next.item;
        probe_reg.merged <= probe_next.merged;
        probe_reg.slot   <= probe_next.slot;
        if (match) begin
            entry_reg <= merged;
        end else if (append) begin
            entry_reg <= app_item;
            year_reg  <= app_year;
        end
    end

    assign probe_out = probe_reg;
endmodule

[rtl/keyed_min_max_sum_aggregator.sv]
// ----------------------------------------------------------------------------
// keyed_min_max_sum_aggregator
// per-year min/max/sum table built as a row of slot cells
// ----------------------------------------------------------------------------
// path: the input beat is registered in every cell of the row, then in
//   res_reg as the state moves to ST_OUT; a new item is taken in ST_IDLE
//   only, once the probe has walked the cell row and the result is taken
// reset: aresetn clears fill level and control; table contents stay
//   undefined until written
module keyed_min_max_sum_aggregator #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // year, game_count, windows_count, mac_count, linux_count, top_price,
    // top_name_id, low_price, low_name_id, price_sum
    input  logic [kmmsa_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // slot, was_new, table_full, merged_count, merged_windows, merged_mac,
    // merged_linux, merged_top_price, merged_top_name, merged_low_price,
    // merged_low_name, merged_price_sum
    output logic [kmmsa_pkg::M_TDATA_W-1:0]   m_tdata
);
    import kmmsa_pkg::*;

    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);

    state_t            state_reg, state_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    probe_t            chain [TABLE_ENTRIES+1];
    probe_t            head;
    entry_t            in_item;
    logic [M_TDATA_W-1:0] res_reg, res_next;
    probe_t            tail;
    logic              app_do;

    always_comb begin
        in_item.count     = CNT_W'(s_tdata[27:12]);
        in_item.windows_c = CNT_W'(s_tdata[43:28]);
        in_item.mac_c     = CNT_W'(s_tdata[59:44]);
        in_item.linux_c   = CNT_W'(s_tdata[75:60]);
        in_item.top_price = s_tdata[99:76];
        in_item.top_name  = s_tdata[115:100];
        in_item.low_price = s_tdata[139:116];
        in_item.low_name  = s_tdata[155:140];
        in_item.price_sum = SUM_W'(s_tdata[187:156]);
        head.vld    = s_tvalid && s_tready;
        head.hit    = 1'b0;
        head.year   = s_tdata[11:0];
        head.item   = in_item;
        head.merged = '0;
        head.slot   = '0;
    end

    assign chain[0] = head;
    assign tail     = chain[TABLE_ENTRIES];
    assign app_do   = tail.vld && !tail.hit &&
                      (fill_reg < FILL_W'(TABLE_ENTRIES));

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        kmmsa_cell #(.IDX_W(IDX_W)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .idx       (IDX_W'(g)),
            .occupied  (FILL_W'(g) < fill_reg),
            .append    (app_do && (fill_reg == FILL_W'(g))),
            .app_year  (tail.year),
            .app_item  (tail.item),
            .probe_in  (chain[g]),
            .probe_out (chain[g+1])
        );
    end

    // the append into a cell happens while the probe sits at the tail,
    // so that cell's own input is read from the tail beat
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_RUN;
            ST_RUN:  if (tail.vld) state_next = ST_OUT;
            ST_OUT:  if (m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        m_tvalid  = (state_reg == ST_OUT);
        fill_next = fill_reg + FILL_W'(app_do);
        res_next  = res_reg;
        if (tail.vld) begin
            if (tail.hit) begin
                res_next = {tail.merged.price_sum, tail.merged.low_name,
                            tail.merged.low_price, tail.merged.top_name,
                            tail.merged.top_price, tail.merged.linux_c,
                            tail.merged.mac_c, tail.merged.windows_c,
                            tail.merged.count, 1'b0, 1'b0, tail.slot[5:0]};
            end else if (app_do) begin
                res_next = {tail.item.price_sum, tail.item.low_name,
                            tail.item.low_price, tail.item.top_name,
                            tail.item.top_price, tail.item.linux_c,
                            tail.item.mac_c, tail.item.windows_c,
                            tail.item.count, 1'b0, 1'b1,
                            SLOT_W'(fill_reg)};
            end else begin
                res_next = {{(M_TDATA_W-8){1'b0}}, 1'b1, 1'b0, 6'd0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
        res_reg <= res_next;
    end

    assign m_tdata = res_reg;
endmodule

[rtl/kmmsa_checker.sv]
// ----------------------------------------------------------------------------
// kmmsa_checker
// port-level checks of the aggregator stream behavior
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module kmmsa_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [223:0] m_tdata
);
    `ASSERT_CLK(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result dropped")
    `ASSERT_CLK(a_excl, aclk, aresetn, !(m_tvalid && s_tready), "accepting while result pending")
    `ASSERT_CLK(a_busy, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "second beat taken in flight")
    `ASSERT_CLK(a_flags, aclk, aresetn, m_tvalid |-> !(m_tdata[6] && m_tdata[7]), "new and full both set")
    `ASSERT_CLK(a_full0, aclk, aresetn, m_tvalid && m_tdata[7] |-> m_tdata[223:8] == '0, "full result not zero")
endmodule

bind keyed_min_max_sum_aggregator kmmsa_checker u_kmmsa_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
